// ===== rtl/hcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// hcpa_pkg
// Shared types and codes for the hierarchical core packing allocator.
// ----------------------------------------------------------------------------
package hcpa_pkg;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_BIND  = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_ADOPT = 2'd3;

  localparam logic [1:0] ST_CHOSEN = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  localparam logic [1:0] TIER_SOCKET = 2'd0;
  localparam logic [1:0] TIER_NODE   = 2'd1;
  localparam logic [1:0] TIER_ANY    = 2'd2;

  // Kind of result offered by the controller.
  localparam logic [1:0] KIND_CHOSEN = 2'd0;
  localparam logic [1:0] KIND_NOFIT  = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  localparam int MAX_REQ = 32;

  typedef enum logic [3:0] {
    S_IDLE,     // waiting for a command
    S_UPD,      // walk cores for bind, free or adopt
    S_CHECK,    // host free check
    S_WIN,      // check the counters of the current window
    S_SCAN,     // count free cores in the current window
    S_EMIT,     // walk the chosen window and emit cores
    S_NOFIT,    // emit one no-fit result
    S_RESULT    // emit the update result
  } hcpa_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic upd_step;    // update the core at the cursor
    logic scan_start;  // set the cursor to the window top, clear tally
    logic scan_step;   // step the cursor and count a free core
    logic emit_start;  // restart the cursor at the window top
    logic emit_step;   // step to the next core, counting the current one if free
    logic next_window; // move on to the next candidate window
  } hcpa_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       is_alloc;
    logic       host_ok;    // request nonzero, in range and fits the host
    logic       at_bottom;  // cursor is at the window bottom
    logic       win_ok;     // window counters allow the request
    logic       win_found;  // tally plus the core at the cursor reaches the request
    logic       no_window;  // all windows tried
    logic       cur_free;   // core at the cursor is unbound
    logic       emit_last;  // current emit is the final one
  } hcpa_stat_t;

endpackage

// ===== rtl/hcpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcpa_ctrl
// Sequencer for updates, window searches and result delivery.
// ----------------------------------------------------------------------------
module hcpa_ctrl
  import hcpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  res_kind,   // chosen, no fit or update
  input  hcpa_stat_t  stat,
  output hcpa_cmd_t   cmd
);

  hcpa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res_kind  = KIND_CHOSEN;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_alloc) begin
          state_nxt = S_UPD;
        end else if (!stat.host_ok) begin
          state_nxt = S_NOFIT;
        end else begin
          state_nxt = S_WIN;
        end
      end
      S_UPD: begin
        cmd.upd_step = 1'b1;
        if (stat.at_bottom) begin
          state_nxt = S_RESULT;
        end
      end
      S_WIN: begin
        if (stat.no_window) begin
          state_nxt = S_NOFIT;
        end else if (!stat.win_ok) begin
          cmd.next_window = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.win_found) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT;
        end else if (stat.at_bottom) begin
          cmd.next_window = 1'b1;
          state_nxt       = S_WIN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.cur_free) begin
          res_valid = 1'b1;
          res_kind  = KIND_CHOSEN;
          if (res_ready) begin
            cmd.emit_step = 1'b1;
            if (stat.emit_last) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          cmd.emit_step = 1'b1;
        end
      end
      S_NOFIT: begin
        res_valid = 1'b1;
        res_kind  = KIND_NOFIT;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_RESULT: begin
        res_valid = 1'b1;
        res_kind  = KIND_UPDATE;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hcpa_dp.sv =====
// ----------------------------------------------------------------------------
// hcpa_dp
// Counters, cursor, window walk and request tally.
// ----------------------------------------------------------------------------
module hcpa_dp
  import hcpa_pkg::*;
#(
  parameter int NODES            = 2,
  parameter int SOCKETS_PER_NODE = 2,
  parameter int CORES_PER_SOCKET = 8,
  parameter int COUNT_WIDTH      = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_request_count,
  input  logic [31:0] in_core_mask,
  input  hcpa_cmd_t   cmd,
  output hcpa_stat_t  stat,
  output logic [4:0]  cur_index,
  output logic [1:0]  cur_tier,
  output logic        sat
);

  localparam int TS  = NODES * SOCKETS_PER_NODE;
  localparam int TC  = TS * CORES_PER_SOCKET;
  localparam int CPN = SOCKETS_PER_NODE * CORES_PER_SOCKET;
  localparam int CW  = (TC > 1) ? $clog2(TC) : 1;
  localparam int SW  = (TS > 1) ? $clog2(TS) : 1;
  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int UW  = $clog2(TC + 1) + COUNT_WIDTH + 1;  // used totals with room for req
  localparam int WN  = TS + NODES + 1;        // number of windows
  localparam int WW  = $clog2(WN + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic [COUNT_WIDTH-1:0] cnt_r [TC];
  logic [UW-1:0] sock_r [TS];
  logic [UW-1:0] node_r [NODES];
  logic [UW-1:0] host_r;

  logic [1:0]  op_r;
  logic [5:0]  req_r;
  logic [31:0] mask_r;
  logic        sat_r;
  logic [CW-1:0] cur_r;
  logic [5:0]  tally_r;
  logic [WW-1:0] win_r;   // sockets high down, then nodes, then host

  // Window bounds and used total.
  logic [CW-1:0] w_hi, w_lo;
  logic [UW-1:0] w_used, w_size;
  logic [1:0]    w_tier;
  logic [SW-1:0] ws;
  logic [NW-1:0] wn;
  always_comb begin
    ws = '0; wn = '0;
    if (win_r < WW'(TS)) begin
      ws     = SW'(TS - 1 - int'(win_r));
      w_hi   = CW'((int'(ws) + 1) * CORES_PER_SOCKET - 1);
      w_lo   = CW'(int'(ws) * CORES_PER_SOCKET);
      w_used = sock_r[ws];
      w_size = UW'(CORES_PER_SOCKET);
      w_tier = TIER_SOCKET;
    end else if (win_r < WW'(TS + NODES)) begin
      wn     = NW'(TS + NODES - 1 - int'(win_r));
      w_hi   = CW'((int'(wn) + 1) * CPN - 1);
      w_lo   = CW'(int'(wn) * CPN);
      w_used = node_r[wn];
      w_size = UW'(CPN);
      w_tier = TIER_NODE;
    end else begin
      w_hi   = CW'(TC - 1);
      w_lo   = '0;
      w_used = host_r;
      w_size = UW'(TC);
      w_tier = TIER_ANY;
    end
  end

  // A socket window also needs its node to pass the node check.
  logic [NW-1:0] ws_node;
  always_comb begin
    ws_node = '0;
    for (int n = 1; n < NODES; n++) begin
      if (int'(ws) >= n * SOCKETS_PER_NODE) ws_node = NW'(n);
    end
  end
  logic node_of_sock_ok;
  assign node_of_sock_ok = (node_r[ws_node] + UW'(req_r)) <= UW'(CPN);

  logic cur_free;
  assign cur_free = (cnt_r[cur_r] == '0);

  assign stat.is_alloc  = (op_r == CMD_ALLOC);
  assign stat.host_ok   = (req_r != 6'd0) && (req_r <= 6'(MAX_REQ))
                          && ((host_r + UW'(req_r)) <= UW'(TC));
  assign stat.at_bottom = (cur_r == w_lo);
  assign stat.win_ok    = ((w_used + UW'(req_r)) <= w_size)
                          && ((win_r >= WW'(TS)) || node_of_sock_ok);
  assign stat.win_found = ((tally_r + 6'(cur_free)) == req_r);
  assign stat.no_window = (win_r == WW'(WN));
  assign stat.cur_free  = cur_free;
  assign stat.emit_last = (tally_r == req_r - 6'd1);

  assign cur_index = 5'(cur_r);
  assign cur_tier  = w_tier;
  assign sat       = sat_r;

  // Socket and node of the cursor core, found by comparing against the
  // unit boundaries.
  logic [SW-1:0] cs;
  logic [NW-1:0] cn;
  logic          mbit;
  always_comb begin
    cs = '0;
    for (int s = 1; s < TS; s++) begin
      if (int'(cur_r) >= s * CORES_PER_SOCKET) cs = SW'(s);
    end
  end
  always_comb begin
    cn = '0;
    for (int n = 1; n < NODES; n++) begin
      if (int'(cur_r) >= n * CPN) cn = NW'(n);
    end
  end
  assign mbit = (int'(cur_r) < 32) ? mask_r[5'(cur_r)] : 1'b0;

  // Update step: decide direction for the core at the cursor.
  logic up, dn;
  always_comb begin
    up = 1'b0; dn = 1'b0;
    if (mbit) begin
      case (op_r)
        CMD_BIND:  up = (cnt_r[cur_r] != CMAX);
        CMD_FREE:  dn = !cur_free;
        CMD_ADOPT: up = cur_free;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TC; i++) cnt_r[i] <= '0;
      for (int i = 0; i < TS; i++) sock_r[i] <= '0;
      for (int i = 0; i < NODES; i++) node_r[i] <= '0;
      host_r <= '0;
      sat_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        sat_r <= 1'b0;
      end
      if (cmd.upd_step) begin
        if (mbit && ((op_r == CMD_BIND && !up) || (op_r == CMD_FREE && !dn))) begin
          sat_r <= 1'b1;
        end
        if (up) begin
          cnt_r[cur_r] <= cnt_r[cur_r] + 1'b1;
          sock_r[cs]   <= sock_r[cs] + 1'b1;
          node_r[cn]   <= node_r[cn] + 1'b1;
          host_r       <= host_r + 1'b1;
        end else if (dn) begin
          cnt_r[cur_r] <= cnt_r[cur_r] - 1'b1;
          sock_r[cs]   <= sock_r[cs] - 1'b1;
          node_r[cn]   <= node_r[cn] - 1'b1;
          host_r       <= host_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_command;
      req_r   <= in_request_count;
      mask_r  <= in_core_mask;
      win_r   <= (in_command == CMD_ALLOC) ? '0 : WW'(TS + NODES);
      cur_r   <= CW'(TC - 1);
      tally_r <= '0;
    end
    if (cmd.upd_step) begin
      cur_r <= cur_r - 1'b1;
    end
    if (cmd.scan_start || cmd.emit_start) begin
      cur_r   <= w_hi;
      tally_r <= '0;
    end
    if (cmd.scan_step) begin
      cur_r   <= cur_r - 1'b1;
      tally_r <= tally_r + 6'(cur_free);
    end
    if (cmd.emit_step) begin
      cur_r   <= cur_r - 1'b1;
      tally_r <= tally_r + 6'(cur_free);
    end
    if (cmd.next_window) begin
      win_r <= win_r + 1'b1;
    end
  end

endmodule

// ===== rtl/hierarchical_core_packing_allocator.sv =====
// ----------------------------------------------------------------------------
// hierarchical_core_packing_allocator
// Core allocator with per-core bind counts and socket, node, host totals.
// ----------------------------------------------------------------------------
// Usage: an input transfer on in_valid/in_ready carries a command, a request
// count and a core mask. Allocate yields request_count result transfers of
// chosen cores (or one no-fit result); bind, free and adopt yield one result.
// out_last marks the final result transfer of each command.
// One command at a time. Updates walk every core, one a cycle, then offer the
// result; the next command is taken once the result has transferred. An
// allocate checks the counters of each candidate window in turn (sockets, then
// nodes, then the host), scans each window that passes to count its free cores,
// then rescans the chosen window to emit, one core a cycle unless the receiver
// stalls a free core.
// Results leave from the controller state directly; when the receiver stalls
// the cursor and state hold until out_ready. Reset clears all counters at once.
// ----------------------------------------------------------------------------
module hierarchical_core_packing_allocator
  import hcpa_pkg::*;
#(
  parameter int NODES            = 2,
  parameter int SOCKETS_PER_NODE = 2,
  parameter int CORES_PER_SOCKET = 8,
  parameter int COUNT_WIDTH      = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_request_count,
  input  logic [31:0] in_core_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_core_index,
  output logic [1:0]  out_tier,
  output logic        out_last
);

  hcpa_cmd_t  cmd;
  hcpa_stat_t stat;
  logic [1:0] kind;
  logic [4:0] idx;
  logic [1:0] tr;
  logic       sat;

  hcpa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready,
    .res_valid(out_valid), .res_ready(out_ready), .res_kind(kind),
    .stat, .cmd
  );

  hcpa_dp #(
    .NODES(NODES), .SOCKETS_PER_NODE(SOCKETS_PER_NODE),
    .CORES_PER_SOCKET(CORES_PER_SOCKET), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk, .rst_n, .in_command, .in_request_count, .in_core_mask,
    .cmd, .stat, .cur_index(idx), .cur_tier(tr), .sat
  );

  always_comb begin
    case (kind)
      KIND_CHOSEN: begin
        out_status     = ST_CHOSEN;
        out_core_index = idx;
        out_tier       = tr;
        out_last       = stat.emit_last;
      end
      KIND_NOFIT: begin
        out_status     = ST_NOFIT;
        out_core_index = '0;
        out_tier       = '0;
        out_last       = 1'b1;
      end
      default: begin
        out_status     = sat ? ST_SAT : ST_DONE;
        out_core_index = '0;
        out_tier       = '0;
        out_last       = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/hcpa_checker.sv =====
// ----------------------------------------------------------------------------
// hcpa_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module hcpa_checker
  import hcpa_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [4:0] out_core_index,
  input logic [1:0] out_tier,
  input logic       out_last
);

  // No new command is taken while a result is offered.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during results");

  // Non-chosen results are always final and carry zero fields.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_CHOSEN) |->
      (out_last && out_core_index == 5'd0 && out_tier == 2'd0))
    else $error("bad single result");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_core_index)))
    else $error("result changed under stall");

  // Tier is never beyond anywhere.
  a_tier: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tier != 2'd3)) else $error("bad tier");

endmodule

bind hierarchical_core_packing_allocator hcpa_checker u_hcpa_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_core_index, .out_tier, .out_last
);
